FILE: rtl/core/restart_schedule_generator_defines.svh
// assertion macros for the restart schedule generator
`ifndef RESTART_SCHEDULE_GENERATOR_DEFINES_SVH
`define RESTART_SCHEDULE_GENERATOR_DEFINES_SVH

// antecedent holds, consequent holds in the same cycle
`define RSG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent holds, consequent holds in the next cycle
`define RSG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/rsg_pkg.sv
// constants and helpers for the restart schedule generator
`timescale 1ns / 1ps
package rsg_pkg;

  localparam int FRAC_BITS = 16;
  localparam int QW        = 64 + FRAC_BITS;   // widest non-overflowing fixed-point value
  localparam int LIMB_W    = 96;               // three 32-bit limbs
  localparam int ACC_W     = 192;              // full 96 x 96 product

  localparam logic [1:0] ACT_ADVANCE = 2'd0;
  localparam logic [1:0] ACT_JUMP    = 2'd1;
  localparam logic [1:0] ACT_REWIND  = 2'd2;
  localparam logic [1:0] ACT_HOLD    = 2'd3;

  localparam logic [1:0] MODE_GEOMETRIC  = 2'd0;
  localparam logic [1:0] MODE_ARITHMETIC = 2'd1;
  localparam logic [1:0] MODE_LUBY       = 2'd2;
  localparam logic [1:0] MODE_FIXED      = 2'd3;

  localparam logic [1:0] CFG_SCHED_TYPE  = 2'd0;
  localparam logic [1:0] CFG_BASE_VALUE  = 2'd1;
  localparam logic [1:0] CFG_GROWTH      = 2'd2;
  localparam logic [1:0] CFG_ROUND_LIMIT = 2'd3;

  function automatic logic [31:0] sat32(input logic [49:0] v);
    logic [31:0] r;
    r = (v[49:32] != '0) ? 32'hFFFF_FFFF : v[31:0];
    return r;
  endfunction

endpackage

FILE: rtl/core/restart_schedule_generator.sv
// restart schedule generator: position/round tracking and limit computation
`timescale 1ns / 1ps
`include "restart_schedule_generator_defines.svh"

// One item at a time, built around a single shared 32x32 multiplier with a
// registered product and a small sequencer. in_ready_o is high only while
// the block waits for an item; a finished result sits in the output register
// and the next item may be taken meanwhile. Rewind in Luby mode runs a
// power-of-two search; a Luby jump past the round skips one round at a
// time; any other jump past the round runs a 17-step binary search over
// the number of rounds skipped. Luby values strip one bit or do one
// subtraction per cycle. Geometric values run square-and-multiply over the
// position bits, each fixed-point multiply being 9 limb products.
module restart_schedule_generator
  import rsg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [31:0] target_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] limit_value_o,
  output logic [31:0] position_o,
  output logic [31:0] round_length_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  typedef enum logic [4:0] {
    S_IDLE, S_ACT, S_REW, S_LJMP, S_JA, S_JB, S_JC, S_JFIN,
    S_VAL, S_AR, S_LUB, S_LMUL, S_GEO, S_GSQ, S_QM, S_QEND, S_FIN
  } state_e;

  localparam logic [QW-1:0] QONE = QW'(1) << FRAC_BITS;

  state_e state_q;

  logic [1:0]  sched_q;
  logic [31:0] base_q, growth_q, rlimit_q;
  logic [31:0] pos_q, len_q;
  logic [1:0]  act_q;
  logic [31:0] n_q;
  logic [32:0] p_q;
  logic [17:0] lo_q, hi_q, mid_q;
  logic [49:0] flo_q, tmp_q;
  logic [32:0] li_q;
  logic [5:0]  lk_q;
  logic [QW-1:0] r_q, s_q;
  logic [31:0] e_q;
  logic        shuge_q, qsq_q;
  logic [ACC_W-1:0] acc_q;
  logic [3:0]  k_q;
  logic [1:0]  qi_q, qj_q;
  logic [2:0]  off_q;
  logic [63:0] prod_q, res_q;
  logic        out_valid_q;
  logic [63:0] lim_out_q;
  logic [31:0] pos_out_q, len_out_q;

  logic [31:0] mul_a, mul_b;
  logic [31:0] pinc;
  logic [33:0] adv_nl;
  logic [18:0] mid_sum;
  logic [17:0] mid_c;
  logic [49:0] f_c;
  logic [32:0] lsum;
  logic [LIMB_W-1:0] qa_pad, qb_pad;
  logic [31:0] limb_a, limb_b;
  logic [33:0] rew_v;
  logic [ACC_W-1:0] acc_add;

  always_comb begin
    pinc    = pos_q + 32'd1;
    adv_nl  = {2'b0, len_q} + ((len_q != 32'd0) ? 34'd1 : 34'd0);
    if (sched_q == MODE_LUBY) begin
      adv_nl = adv_nl << 1;
    end
    mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
    mid_c   = mid_sum[18:1];
    f_c     = tmp_q + {16'b0, prod_q[34:1]};
    lsum    = li_q + 33'd1;
    qa_pad  = LIMB_W'(qsq_q ? s_q : r_q);
    qb_pad  = LIMB_W'(s_q);
    limb_a  = qa_pad[32*qi_q +: 32];
    limb_b  = qb_pad[32*qj_q +: 32];
    rew_v   = ({1'b0, p_q} - 34'd1) << 1;
    if (rew_v < 34'd2) begin
      rew_v = 34'd2;
    end
    acc_add = acc_q + (ACC_W'(prod_q) << {off_q, 5'b0});
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_VAL: begin
        mul_a = growth_q;
        mul_b = pos_q;
      end
      S_JA: begin
        mul_a = {14'b0, mid_c};
        mul_b = len_q;
      end
      S_JB: begin
        mul_a = {14'b0, mid_q};
        mul_b = {14'b0, mid_q - 18'd1};
      end
      S_LUB: begin
        mul_a = lsum[32:1];
        mul_b = base_q;
      end
      S_QM: begin
        mul_a = limb_a;
        mul_b = limb_b;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sched_q     <= MODE_FIXED;
      base_q      <= 32'd100;
      growth_q    <= 32'd98304;
      rlimit_q    <= 32'd0;
      pos_q       <= '0;
      len_q       <= '0;
      act_q       <= '0;
      n_q         <= '0;
      p_q         <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      mid_q       <= '0;
      flo_q       <= '0;
      tmp_q       <= '0;
      li_q        <= '0;
      lk_q        <= '0;
      r_q         <= '0;
      s_q         <= '0;
      e_q         <= '0;
      shuge_q     <= 1'b0;
      qsq_q       <= 1'b0;
      acc_q       <= '0;
      k_q         <= '0;
      qi_q        <= '0;
      qj_q        <= '0;
      off_q       <= '0;
      prod_q      <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      lim_out_q   <= '0;
      pos_out_q   <= '0;
      len_out_q   <= '0;
    end else begin
      prod_q <= 64'(mul_a) * 64'(mul_b);

      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_SCHED_TYPE:  sched_q  <= cfg_data_i[1:0];
          CFG_BASE_VALUE:  base_q   <= cfg_data_i;
          CFG_GROWTH:      growth_q <= cfg_data_i;
          CFG_ROUND_LIMIT: rlimit_q <= cfg_data_i;
          default: ;
        endcase
      end

      // the finish state refills the output register itself
      if (out_valid_q && out_ready_i && state_q != S_FIN) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            act_q   <= action_i;
            n_q     <= target_i;
            state_q <= S_ACT;
          end
        end
        S_ACT: begin
          case (act_q)
            ACT_ADVANCE: begin
              if (pinc == len_q) begin
                len_q <= sat32(50'(adv_nl));
                pos_q <= '0;
              end else begin
                pos_q <= pinc;
              end
              state_q <= S_VAL;
            end
            ACT_JUMP: begin
              if (len_q == 32'd0 || n_q < len_q) begin
                pos_q   <= n_q;
                state_q <= S_VAL;
              end else if (sched_q == MODE_LUBY) begin
                state_q <= S_LJMP;
              end else begin
                lo_q    <= '0;
                hi_q    <= 18'd1 << 17;
                flo_q   <= '0;
                state_q <= S_JA;
              end
            end
            ACT_REWIND: begin
              pos_q <= '0;
              if (sched_q != MODE_LUBY || rlimit_q == 32'd0) begin
                len_q   <= rlimit_q;
                state_q <= S_VAL;
              end else begin
                p_q     <= 33'd1;
                state_q <= S_REW;
              end
            end
            default: state_q <= S_VAL;
          endcase
        end
        S_REW: begin
          if (p_q < {1'b0, rlimit_q}) begin
            p_q <= p_q << 1;
          end else begin
            len_q   <= sat32(50'(rew_v));
            state_q <= S_VAL;
          end
        end
        S_LJMP: begin
          // skip whole rounds, each one longer than the last
          if (n_q >= len_q) begin
            n_q   <= n_q - len_q;
            len_q <= sat32(50'(({2'b0, len_q} + 34'd1) << 1));
          end else begin
            pos_q   <= n_q;
            state_q <= S_VAL;
          end
        end
        S_JA: begin
          if (hi_q - lo_q > 18'd1) begin
            mid_q   <= mid_c;
            state_q <= S_JB;
          end else begin
            state_q <= S_JFIN;
          end
        end
        S_JB: begin
          tmp_q   <= prod_q[49:0];
          state_q <= S_JC;
        end
        S_JC: begin
          // rounds start at mid*len + mid*(mid-1)/2
          if (f_c <= {18'b0, n_q}) begin
            lo_q  <= mid_q;
            flo_q <= f_c;
          end else begin
            hi_q <= mid_q;
          end
          state_q <= S_JA;
        end
        S_JFIN: begin
          pos_q   <= n_q - flo_q[31:0];
          len_q   <= sat32({18'b0, len_q} + {32'b0, lo_q});
          state_q <= S_VAL;
        end
        S_VAL: begin
          if (base_q == 32'd0) begin
            res_q   <= '1;
            state_q <= S_FIN;
          end else begin
            case (sched_q)
              MODE_GEOMETRIC: begin
                r_q     <= QW'(base_q) << FRAC_BITS;
                s_q     <= (QW'(growth_q) < QONE) ? QONE : QW'(growth_q);
                e_q     <= pos_q;
                shuge_q <= 1'b0;
                state_q <= S_GEO;
              end
              MODE_ARITHMETIC: state_q <= S_AR;
              MODE_LUBY: begin
                li_q    <= {1'b0, pos_q} + 33'd1;
                lk_q    <= 6'd32;
                state_q <= S_LUB;
              end
              default: begin
                res_q   <= {32'b0, base_q};
                state_q <= S_FIN;
              end
            endcase
          end
        end
        S_AR: begin
          res_q   <= (prod_q >> FRAC_BITS) + {32'b0, base_q};
          state_q <= S_FIN;
        end
        S_LUB: begin
          // strip the top bit and add one until the value is all ones
          if ((li_q & lsum) == 33'd0) begin
            state_q <= S_LMUL;
          end else if (!li_q[lk_q]) begin
            lk_q <= lk_q - 6'd1;
          end else begin
            li_q <= li_q - ((33'd1 << lk_q) - 33'd1);
          end
        end
        S_LMUL: begin
          res_q   <= prod_q;
          state_q <= S_FIN;
        end
        S_GEO: begin
          if (e_q == 32'd0) begin
            res_q   <= r_q[QW-1:FRAC_BITS];
            state_q <= S_FIN;
          end else if (e_q[0]) begin
            if (shuge_q) begin
              res_q   <= '1;
              state_q <= S_FIN;
            end else begin
              qsq_q   <= 1'b0;
              acc_q   <= '0;
              k_q     <= '0;
              qi_q    <= '0;
              qj_q    <= '0;
              state_q <= S_QM;
            end
          end else begin
            state_q <= S_GSQ;
          end
        end
        S_GSQ: begin
          e_q <= e_q >> 1;
          if ((e_q >> 1) != 32'd0 && !shuge_q) begin
            qsq_q   <= 1'b1;
            acc_q   <= '0;
            k_q     <= '0;
            qi_q    <= '0;
            qj_q    <= '0;
            state_q <= S_QM;
          end else begin
            state_q <= S_GEO;
          end
        end
        S_QM: begin
          // product of limb pair k lands in the next cycle
          if (k_q < 4'd9) begin
            off_q <= 3'(qi_q) + 3'(qj_q);
            if (qj_q == 2'd2) begin
              qj_q <= '0;
              if (qi_q != 2'd2) begin
                qi_q <= qi_q + 2'd1;
              end
            end else begin
              qj_q <= qj_q + 2'd1;
            end
          end
          if (k_q != 4'd0) begin
            acc_q <= acc_add;
          end
          if (k_q == 4'd9) begin
            state_q <= S_QEND;
          end else begin
            k_q <= k_q + 4'd1;
          end
        end
        S_QEND: begin
          if (qsq_q) begin
            if (acc_q[ACC_W-1:QW+FRAC_BITS] != '0) begin
              shuge_q <= 1'b1;
            end else begin
              s_q <= acc_q[QW+FRAC_BITS-1:FRAC_BITS];
            end
            state_q <= S_GEO;
          end else if (acc_q[ACC_W-1:QW+FRAC_BITS] != '0) begin
            res_q   <= '1;
            state_q <= S_FIN;
          end else begin
            r_q     <= acc_q[QW+FRAC_BITS-1:FRAC_BITS];
            state_q <= S_GSQ;
          end
        end
        S_FIN: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            lim_out_q   <= res_q;
            pos_out_q   <= pos_q;
            len_out_q   <= len_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign out_valid_o    = out_valid_q;
  assign limit_value_o  = lim_out_q;
  assign position_o     = pos_out_q;
  assign round_length_o = len_out_q;

  `RSG_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o,
                   "block still ready after taking an item")
  `RSG_ASSERT_NOW(a_pos_in_round, len_q != 32'd0, pos_q < len_q,
                  "position outside the current round")
  `RSG_ASSERT_NOW(a_result_from_fin, $rose(out_valid_o), $past(state_q == S_FIN),
                  "result appeared without a finished computation")

endmodule

FILE: test/testbench.sv
// self-checking testbench for the restart schedule generator
`timescale 1ns / 1ps

class sched_scoreboard;
  logic [1:0]  sched;
  logic [31:0] base, grow, rlim, pos, len;
  logic [63:0] lim_q[$];
  logic [31:0] pos_q[$], len_q[$];
  int          errors;

  function new();
    errors = 0;
    sched = rsg_pkg::MODE_FIXED;
    base = 32'd100;
    grow = 32'd98304;
    rlim = 32'd0;
    pos = 32'd0;
    len = round_len_from_limit();
  endfunction

  function logic [31:0] clip32(input logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  // luby rounds start at twice the power of two covering the limit, minus two
  function logic [31:0] round_len_from_limit();
    logic [63:0] p;
    logic [63:0] v;
    if (sched != rsg_pkg::MODE_LUBY || rlim == 0) return rlim;
    p = 64'd1;
    while (p < rlim) p = p << 1;
    v = (p - 1) * 2;
    if (v < 2) v = 2;
    return clip32(v);
  endfunction

  // fixed-point product truncated to the fraction width, flags reaching 2^80
  function bit fx_mul(input logic [95:0] a, input logic [95:0] b, output logic [95:0] o);
    logic [191:0] p;
    p = ({96'd0, a} * {96'd0, b}) >> rsg_pkg::FRAC_BITS;
    o = p[95:0];
    return p[191:80] != 0;
  endfunction

  function logic [63:0] geom_limit();
    logic [95:0] r, s;
    logic [31:0] g, e;
    bit          s_huge;
    g = grow;
    if (g < (32'd1 << rsg_pkg::FRAC_BITS)) g = 32'd1 << rsg_pkg::FRAC_BITS;
    r = {64'd0, base} << rsg_pkg::FRAC_BITS;
    s = {64'd0, g};
    e = pos;
    s_huge = 0;
    while (e != 0) begin
      if (e[0]) begin
        if (s_huge || fx_mul(r, s, r)) return 64'hFFFF_FFFF_FFFF_FFFF;
      end
      e = e >> 1;
      if (e != 0 && !s_huge) s_huge = fx_mul(s, s, s);
    end
    return r[79:16];
  endfunction

  function logic [63:0] luby_term(input logic [31:0] p);
    logic [63:0] i;
    int          hb;
    i = {32'd0, p} + 64'd1;
    while ((i & (i + 1)) != 0) begin
      hb = 63;
      while (hb > 0 && !i[hb]) hb--;
      i = i - ((64'd1 << hb) - 1);
    end
    return (i + 1) >> 1;
  endfunction

  function logic [63:0] limit_now();
    if (base == 0) return 64'hFFFF_FFFF_FFFF_FFFF;
    case (sched)
      rsg_pkg::MODE_GEOMETRIC:  return geom_limit();
      rsg_pkg::MODE_ARITHMETIC:
        return (({32'd0, grow} * {32'd0, pos}) >> rsg_pkg::FRAC_BITS) + base;
      rsg_pkg::MODE_LUBY:       return luby_term(pos) * {32'd0, base};
      default:                  return {32'd0, base};
    endcase
  endfunction

  function void write_reg(input logic [1:0] idx, input logic [31:0] data);
    case (idx)
      rsg_pkg::CFG_SCHED_TYPE: sched = data[1:0];
      rsg_pkg::CFG_BASE_VALUE: base = data;
      rsg_pkg::CFG_GROWTH:     grow = data;
      default:                 rlim = data;
    endcase
  endfunction

  function void note_input(input logic [1:0] act, input logic [31:0] tgt);
    logic [63:0] n, lo, hi, mid, ln;
    if (act == rsg_pkg::ACT_ADVANCE) begin
      pos = pos + 1;
      if (pos == len) begin
        ln = {32'd0, len} + ((len != 0) ? 64'd1 : 64'd0);
        if (sched == rsg_pkg::MODE_LUBY) ln = ln << 1;
        len = clip32(ln);
        pos = 0;
      end
    end else if (act == rsg_pkg::ACT_JUMP) begin
      if (len == 0 || tgt < len) begin
        pos = tgt;
      end else if (sched == rsg_pkg::MODE_LUBY) begin
        n = {32'd0, tgt};
        while (n >= len) begin
          n = n - len;
          len = clip32(({32'd0, len} + 1) * 2);
        end
        pos = n[31:0];
      end else begin
        // largest whole number of growing rounds that fits below the target
        lo = 0;
        hi = 64'd1 << 17;
        ln = {32'd0, len};
        while (hi - lo > 1) begin
          mid = (lo + hi) >> 1;
          if (mid * ln + mid * (mid - 1) / 2 <= tgt) lo = mid;
          else hi = mid;
        end
        n = {32'd0, tgt} - (lo * ln + lo * (lo - 1) / 2);
        pos = n[31:0];
        len = clip32(ln + lo);
      end
    end else if (act == rsg_pkg::ACT_REWIND) begin
      pos = 0;
      len = round_len_from_limit();
    end
    lim_q = {lim_q, limit_now()};
    pos_q = {pos_q, pos};
    len_q = {len_q, len};
  endfunction

  function void check_result(input logic [63:0] lv, input logic [31:0] p, input logic [31:0] l);
    logic [63:0] e_lim;
    logic [31:0] e_pos, e_len;
    if (lim_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result: limit %0d pos %0d len %0d", lv, p, l);
      return;
    end
    e_lim = lim_q.pop_front();
    e_pos = pos_q.pop_front();
    e_len = len_q.pop_front();
    if (lv !== e_lim || p !== e_pos || l !== e_len) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: limit %0d/%0d pos %0d/%0d len %0d/%0d (expected/actual)",
                 e_lim, lv, e_pos, p, e_len, l);
    end
  endfunction

  function int pending();
    return lim_q.size();
  endfunction
endclass

module testbench;
  import rsg_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  action_i = ACT_ADVANCE;
  logic [31:0] target_i = 32'd0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] limit_value_o;
  logic [31:0] position_o;
  logic [31:0] round_length_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = CFG_SCHED_TYPE;
  logic [31:0] cfg_data_i = 32'd0;

  sched_scoreboard sb = new();
  bit              no_gaps = 0;

  restart_schedule_generator dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // result side: random backpressure (none while no_gaps is set), every accepted item checked
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        sb.check_result(limit_value_o, position_o, round_length_o);
      out_ready_i <= no_gaps ? 1'b1 : ($urandom_range(0, 99) >= 23);
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [1:0] st, input logic [31:0] b, input logic [31:0] g,
                           input logic [31:0] rl);
    write_reg(CFG_SCHED_TYPE, {30'd0, st});
    write_reg(CFG_BASE_VALUE, b);
    write_reg(CFG_GROWTH, g);
    write_reg(CFG_ROUND_LIMIT, rl);
  endtask

  task automatic send_item(input logic [1:0] act, input logic [31:0] tgt);
    if (!no_gaps && $urandom_range(0, 99) < 23) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    target_i   <= tgt;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_input(act, tgt);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic random_items(input int count, input bit hold_mid);
    logic [1:0]  act;
    logic [31:0] tgt;
    int          r;
    for (int k = 0; k < count; k++) begin
      if (hold_mid && k == count / 2) drain();
      r = $urandom_range(0, 99);
      act = (r < 55) ? ACT_ADVANCE : (r < 80) ? ACT_JUMP : (r < 95) ? ACT_REWIND : ACT_HOLD;
      r = $urandom_range(0, 99);
      tgt = (r < 40) ? $urandom_range(0, 64) : (r < 70) ? $urandom_range(0, 4095) : $urandom;
      send_item(act, tgt);
    end
  endtask

  initial begin
    #40_000_000;
    $display("** restart_schedule_generator: FAILED **");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings, then the extremes of every field and mode
    send_item(ACT_ADVANCE, 32'd0);
    send_item(ACT_JUMP, 32'hFFFF_FFFF);
    send_item(ACT_ADVANCE, 32'd0);
    send_item(ACT_HOLD, 32'h5A5A_5A5A);
    drain();
    configure(MODE_GEOMETRIC, 32'hFFFF_FFFF, 32'd0, 32'd1);
    send_item(ACT_REWIND, 32'd0);
    send_item(ACT_ADVANCE, 32'd0);
    send_item(ACT_JUMP, 32'd0);
    send_item(ACT_JUMP, 32'd10);
    drain();
    configure(MODE_GEOMETRIC, 32'd7, 32'hFFFF_FFFF, 32'd0);
    send_item(ACT_REWIND, 32'd0);
    send_item(ACT_JUMP, 32'd3);
    send_item(ACT_JUMP, 32'hFFFF_FFFF);
    drain();
    configure(MODE_ARITHMETIC, 32'd0, 32'hFFFF_FFFF, 32'h8000_0000);
    send_item(ACT_REWIND, 32'd0);
    send_item(ACT_JUMP, 32'hFFFF_FFFF);
    drain();
    write_reg(CFG_BASE_VALUE, 32'hFFFF_FFFF);
    send_item(ACT_JUMP, 32'h7FFF_FFFF);
    send_item(ACT_ADVANCE, 32'd0);
    drain();
    configure(MODE_LUBY, 32'd1, 32'd0, 32'h8000_0000);
    send_item(ACT_REWIND, 32'd0);
    send_item(ACT_JUMP, 32'hFFFF_FFFE);
    send_item(ACT_JUMP, 32'hFFFF_FFFF);
    drain();
    write_reg(CFG_ROUND_LIMIT, 32'd1);
    send_item(ACT_REWIND, 32'd0);
    send_item(ACT_ADVANCE, 32'd0);
    send_item(ACT_ADVANCE, 32'd0);
    send_item(ACT_JUMP, 32'hFFFF_FFFF);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: configure(MODE_GEOMETRIC, $urandom_range(1, 1000),
                     32'h0001_0000 + $urandom_range(0, 40000), $urandom_range(1, 20));
        1: configure(MODE_ARITHMETIC, $urandom, $urandom, $urandom_range(0, 50));
        2: configure(MODE_LUBY, $urandom_range(1, 500), $urandom, $urandom_range(1, 40));
        3: configure(MODE_FIXED, $urandom, $urandom, 32'h8000_0000);
        4: configure(MODE_GEOMETRIC, $urandom, $urandom_range(0, 32'h0003_0000), 32'd0);
        5: configure(MODE_LUBY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        6: configure(MODE_ARITHMETIC, 32'd1, 32'd0, 32'd1);
        default: configure(2'($urandom_range(0, 3)), $urandom_range(0, 1) ? 32'd0 : $urandom,
                           $urandom, $urandom_range(0, 8));
      endcase
      no_gaps = (ph == 5);
      send_item(ACT_REWIND, 32'd0);
      random_items(190, ph == 3);
      drain();
      no_gaps = 0;
    end

    repeat (800) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("** restart_schedule_generator: PASSED **");
    else
      $display("** restart_schedule_generator: FAILED **");
    $finish;
  end
endmodule

FILE: restart_schedule_generator.f
+incdir+rtl/core
rtl/core/rsg_pkg.sv
rtl/core/restart_schedule_generator.sv
test/testbench.sv
